/* design/indexed_list_table_engine_macros.svh */
// Assertion macros shared by the list engine modules.
// Needs nothing else; pulled in by the controller and datapath files.
`ifndef INDEXED_LIST_TABLE_ENGINE_MACROS_SVH
`define INDEXED_LIST_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ILTE_ASSERT_IMPL(name, clk_i, rst_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ILTE_ASSERT_NEXT(name, clk_i, rst_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ilte_pkg.sv */
// Shared types and constants of the indexed list engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package ilte_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;

  // Found position reported when the value is absent (-1 in 7 bits)
  localparam logic [POS_W-1:0] FOUND_NONE = '1;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_FIND   = 3'd4,
    ACT_READ   = 3'd5,
    ACT_WRITE  = 3'd6,
    ACT_CLEAR  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_CNT  = 3'd1,
    IDX_POS  = 3'd2,
    IDX_ZERO = 3'd3,
    IDX_INC  = 3'd4,
    IDX_DEC  = 3'd5
  } idx_op_t;

  typedef enum logic [1:0] {
    RD_POS    = 2'd0,
    RD_IDX    = 2'd1,
    RD_IDX_M1 = 2'd2,
    RD_IDX_P1 = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_CNT = 2'd0,
    WA_POS = 2'd1,
    WA_IDX = 2'd2
  } wa_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef enum logic [1:0] {
    RES_PLAIN = 2'd0,
    RES_READ  = 2'd1,
    RES_FOUND = 2'd2,
    RES_MISS  = 2'd3
  } res_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      take;
    idx_op_t   idx_op;
    rd_sel_t   rd_sel;
    logic      we;
    wa_sel_t   wa_sel;
    logic      wd_rdata;
    cnt_op_t   cnt_op;
    logic      res_load;
    logic      res_ok;
    res_kind_t res_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t act;
    logic    full;
    logic    empty;
    logic    pos_lt_cnt;
    logic    pos_le_cnt;
    logic    idx_gt_pos;
    logic    idx_next_lt_cnt;
    logic    idx_lt_cnt;
    logic    hit;
    logic    out_free;
  } status_t;

endpackage

/* design/indexed_list_table_engine.sv */
// Channel  Handshake            Beat contents
// in       in_valid/in_ready    action, value, position
// out      out_valid/out_ready  ok, read_value, found_position, count, is_empty
//
// One item at a time; in_ready is high only while the controller is idle.
// Append, remove, write, clear and every rejected action finish in the execute step;
// read adds a wait step (S_RD_WAIT) for the registered RAM read. Insert and erase
// shift one entry per read step (S_SH_RD) and write step (S_SH_WR); find walks from
// index 0 with a read step (S_FD_RD) and a compare step (S_FD_CMP) for each entry,
// because the RAM read is registered.
// Reset clears the fill count, the controller state and the output valid; entries stay
// undefined until written.
// A stalled output beat holds the controller at its final step; the next item waits.
// Top level: instantiates ilte_ctrl and ilte_dp; uses ilte_pkg.
module indexed_list_table_engine #(
  parameter int CAPACITY = ilte_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           action,
  input  logic signed [ilte_pkg::DATA_W-1:0]   value,
  input  logic [ilte_pkg::POS_W-1:0]           position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 ok,
  output logic signed [ilte_pkg::DATA_W-1:0]   read_value,
  output logic signed [ilte_pkg::POS_W-1:0]    found_position,
  output logic [ilte_pkg::POS_W-1:0]           count,
  output logic                                 is_empty
);

  ilte_pkg::cmd_t    cmd;
  ilte_pkg::status_t status;

  ilte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ilte_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .action         (action),
    .value          (value),
    .position       (position),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .ok             (ok),
    .read_value     (read_value),
    .found_position (found_position),
    .count          (count),
    .is_empty       (is_empty)
  );

endmodule

/* design/ilte_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
module ilte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ilte_ctrl.sv */
// Controller state machine of the list engine: sequences each action.
// Depends on ilte_pkg and the assertion macro header.
`include "indexed_list_table_engine_macros.svh"

module ilte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilte_pkg::status_t status,
  output ilte_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EXEC    = 8'b0000_0010,
    S_RD_WAIT = 8'b0000_0100,
    S_SH_RD   = 8'b0000_1000,
    S_SH_WR   = 8'b0001_0000,
    S_FIN     = 8'b0010_0000,
    S_FD_RD   = 8'b0100_0000,
    S_FD_CMP  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   is_insert;

  assign is_insert = (status.act == ilte_pkg::ACT_INSERT);
  assign in_ready  = (state == S_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.idx_op   = ilte_pkg::IDX_HOLD;
    cmd.rd_sel   = ilte_pkg::RD_POS;
    cmd.wa_sel   = ilte_pkg::WA_CNT;
    cmd.cnt_op   = ilte_pkg::CNT_HOLD;
    cmd.res_kind = ilte_pkg::RES_PLAIN;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.act)
          ilte_pkg::ACT_APPEND: begin
            if (status.out_free) begin
              cmd.res_load = 1'b1;
              if (!status.full) begin
                cmd.we     = 1'b1;
                cmd.wa_sel = ilte_pkg::WA_CNT;
                cmd.cnt_op = ilte_pkg::CNT_INC;
                cmd.res_ok = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          ilte_pkg::ACT_REMOVE: begin
            if (status.out_free) begin
              cmd.res_load = 1'b1;
              if (!status.empty) begin
                cmd.cnt_op = ilte_pkg::CNT_DEC;
                cmd.res_ok = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          ilte_pkg::ACT_INSERT: begin
            if (status.pos_le_cnt && !status.full) begin
              cmd.idx_op = ilte_pkg::IDX_CNT;
              state_next = S_SH_RD;
            end else if (status.out_free) begin
              cmd.res_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
          ilte_pkg::ACT_ERASE: begin
            if (status.pos_lt_cnt) begin
              cmd.idx_op = ilte_pkg::IDX_POS;
              state_next = S_SH_RD;
            end else if (status.out_free) begin
              cmd.res_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
          ilte_pkg::ACT_FIND: begin
            cmd.idx_op = ilte_pkg::IDX_ZERO;
            state_next = S_FD_RD;
          end
          ilte_pkg::ACT_READ: begin
            cmd.rd_sel = ilte_pkg::RD_POS;
            if (status.pos_lt_cnt) begin
              state_next = S_RD_WAIT;
            end else if (status.out_free) begin
              cmd.res_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
          ilte_pkg::ACT_WRITE: begin
            if (status.out_free) begin
              cmd.res_load = 1'b1;
              if (status.pos_lt_cnt) begin
                cmd.we     = 1'b1;
                cmd.wa_sel = ilte_pkg::WA_POS;
                cmd.res_ok = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          ilte_pkg::ACT_CLEAR: begin
            if (status.out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_ok   = 1'b1;
              cmd.cnt_op   = ilte_pkg::CNT_CLR;
              state_next   = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RD_WAIT: begin
        // Keep the read address so the data holds while the output stalls
        cmd.rd_sel = ilte_pkg::RD_POS;
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          cmd.res_kind = ilte_pkg::RES_READ;
          state_next   = S_IDLE;
        end
      end
      S_SH_RD: begin
        // Fetch the neighbor that moves into the current slot
        if (is_insert) begin
          if (status.idx_gt_pos) begin
            cmd.rd_sel = ilte_pkg::RD_IDX_M1;
            state_next = S_SH_WR;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          if (status.idx_next_lt_cnt) begin
            cmd.rd_sel = ilte_pkg::RD_IDX_P1;
            state_next = S_SH_WR;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SH_WR: begin
        cmd.we       = 1'b1;
        cmd.wa_sel   = ilte_pkg::WA_IDX;
        cmd.wd_rdata = 1'b1;
        cmd.idx_op   = is_insert ? ilte_pkg::IDX_DEC : ilte_pkg::IDX_INC;
        state_next   = S_SH_RD;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          if (is_insert) begin
            cmd.we     = 1'b1;
            cmd.wa_sel = ilte_pkg::WA_POS;
            cmd.cnt_op = ilte_pkg::CNT_INC;
          end else begin
            cmd.cnt_op = ilte_pkg::CNT_DEC;
          end
          state_next = S_IDLE;
        end
      end
      S_FD_RD: begin
        cmd.rd_sel = ilte_pkg::RD_IDX;
        if (status.idx_lt_cnt) begin
          state_next = S_FD_CMP;
        end else if (status.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          cmd.res_kind = ilte_pkg::RES_MISS;
          state_next   = S_IDLE;
        end
      end
      S_FD_CMP: begin
        cmd.rd_sel = ilte_pkg::RD_IDX;
        if (status.hit) begin
          if (status.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_ok   = 1'b1;
            cmd.res_kind = ilte_pkg::RES_FOUND;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.idx_op = ilte_pkg::IDX_INC;
          state_next = S_FD_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ILTE_ASSERT_IMPL(a_res_needs_room, clk, rst, cmd.res_load, status.out_free, "result loaded over a pending beat")
  `ILTE_ASSERT_NEXT(a_take_to_exec, clk, rst, cmd.take, state == S_EXEC, "accepted item did not reach execute")

endmodule

/* design/ilte_dp.sv */
// Datapath of the list engine: item registers, count, index, entry RAM, result register.
// Depends on ilte_pkg, ilte_ram and the assertion macro header.
`include "indexed_list_table_engine_macros.svh"

module ilte_dp #(
  parameter int CAPACITY = ilte_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [2:0]                           action,
  input  logic signed [ilte_pkg::DATA_W-1:0]   value,
  input  logic [ilte_pkg::POS_W-1:0]           position,
  input  ilte_pkg::cmd_t                       cmd,
  output ilte_pkg::status_t                    status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 ok,
  output logic signed [ilte_pkg::DATA_W-1:0]   read_value,
  output logic signed [ilte_pkg::POS_W-1:0]    found_position,
  output logic [ilte_pkg::POS_W-1:0]           count,
  output logic                                 is_empty
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ilte_pkg::POS_W) ? CW : ilte_pkg::POS_W;

  ilte_pkg::action_t                act_q;
  logic [ilte_pkg::DATA_W-1:0]      val_q;
  logic [ilte_pkg::POS_W-1:0]       pos_q;
  logic [CW-1:0]                    cnt, cnt_next;
  logic [CW-1:0]                    idx, idx_next;
  logic [CW-1:0]                    idx_m1, idx_p1;
  logic [CMPW-1:0]                  pos_x, cnt_x, idx_x;
  logic [AW-1:0]                    raddr, waddr;
  logic [ilte_pkg::DATA_W-1:0]      wdata, rdata;

  // Latch the item on acceptance
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_q <= ilte_pkg::action_t'(action);
      val_q <= value;
      pos_q <= position;
    end
  end

  assign idx_m1 = idx - CW'(1);
  assign idx_p1 = idx + CW'(1);
  assign pos_x  = CMPW'(pos_q);
  assign cnt_x  = CMPW'(cnt);
  assign idx_x  = CMPW'(idx);

  // Next fill count
  always_comb begin
    unique case (cmd.cnt_op)
      ilte_pkg::CNT_HOLD: cnt_next = cnt;
      ilte_pkg::CNT_INC:  cnt_next = cnt + CW'(1);
      ilte_pkg::CNT_DEC:  cnt_next = cnt - CW'(1);
      ilte_pkg::CNT_CLR:  cnt_next = '0;
      default:            cnt_next = cnt;
    endcase
  end

  // Next walk index
  always_comb begin
    unique case (cmd.idx_op)
      ilte_pkg::IDX_HOLD: idx_next = idx;
      ilte_pkg::IDX_CNT:  idx_next = cnt;
      ilte_pkg::IDX_POS:  idx_next = CW'(pos_q);
      ilte_pkg::IDX_ZERO: idx_next = '0;
      ilte_pkg::IDX_INC:  idx_next = idx_p1;
      ilte_pkg::IDX_DEC:  idx_next = idx_m1;
      default:            idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    idx <= idx_next;
  end

  // Address and data selection for the entry RAM
  always_comb begin
    unique case (cmd.rd_sel)
      ilte_pkg::RD_POS:    raddr = AW'(pos_q);
      ilte_pkg::RD_IDX:    raddr = idx[AW-1:0];
      ilte_pkg::RD_IDX_M1: raddr = idx_m1[AW-1:0];
      ilte_pkg::RD_IDX_P1: raddr = idx_p1[AW-1:0];
      default:             raddr = idx[AW-1:0];
    endcase
    unique case (cmd.wa_sel)
      ilte_pkg::WA_CNT: waddr = cnt[AW-1:0];
      ilte_pkg::WA_POS: waddr = AW'(pos_q);
      ilte_pkg::WA_IDX: waddr = idx[AW-1:0];
      default:          waddr = idx[AW-1:0];
    endcase
  end

  assign wdata = cmd.wd_rdata ? rdata : val_q;

  ilte_ram #(
    .WIDTH (ilte_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status back to the controller
  assign status.act             = act_q;
  assign status.full            = (cnt == CW'(CAPACITY));
  assign status.empty           = (cnt == '0);
  assign status.pos_lt_cnt      = (pos_x < cnt_x);
  assign status.pos_le_cnt      = (pos_x <= cnt_x);
  assign status.idx_gt_pos      = (idx_x > pos_x);
  assign status.idx_next_lt_cnt = ({1'b0, idx} + (CW + 1)'(1)) < {1'b0, cnt};
  assign status.idx_lt_cnt      = (idx < cnt);
  assign status.hit             = (rdata == val_q);
  assign status.out_free        = !out_valid || out_ready;

  // Output beat valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      ok       <= cmd.res_ok;
      count    <= ilte_pkg::POS_W'(cnt_next);
      is_empty <= (cnt_next == '0);
      read_value <= (cmd.res_kind == ilte_pkg::RES_READ) ? rdata : '0;
      unique case (cmd.res_kind)
        ilte_pkg::RES_FOUND: found_position <= ilte_pkg::POS_W'(idx);
        ilte_pkg::RES_MISS:  found_position <= ilte_pkg::FOUND_NONE;
        default:             found_position <= '0;
      endcase
    end
  end

  `ILTE_ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, cnt <= CW'(CAPACITY), "fill count above capacity")
  `ILTE_ASSERT_IMPL(a_no_overfill, clk, rst, cmd.cnt_op == ilte_pkg::CNT_INC, cnt != CW'(CAPACITY), "count raised on a full list")

endmodule
